// ----- sv/wpa_pkg.sv -----
// Shared types and constants for the weighted projection amplitude block.
// Holds the sample and result structs, controller/datapath signal groups and fixed widths.
// No dependencies.
package wpa_pkg;

    localparam int SUM_W    = 56;
    localparam int TERM_W   = 48;
    localparam int PROD_W   = 88;
    localparam int DIV_BITS = PROD_W;
    localparam int MAG_W    = 41;

    localparam logic signed [SUM_W-1:0] EPSILON_Q16 = 56'sd7;
    localparam logic signed [SUM_W-1:0] SUM_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN     = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [MAG_W-1:0]        QUOT_CAP    = {1'b1, {(MAG_W-1){1'b0}}};

    localparam logic signed [31:0] MIN_AMP_RESET = 32'sd66;
    localparam logic signed [31:0] MAX_AMP_RESET = 32'sd753664;

    localparam logic [1:0] CFG_MIN_AMP = 2'd0;
    localparam logic [1:0] CFG_MAX_AMP = 2'd1;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_MIN  = 2'd1;
    localparam logic [1:0] CLAMP_MAX  = 2'd2;

    typedef struct packed {
        logic signed [11:0] observed_sample;
        logic signed [11:0] model_sample;
        logic        [11:0] emphasis_weight;
        logic signed [31:0] prior_amplitude;
        logic        [4:0]  flow_number;
        logic               last_sample;
    } sample_t;

    typedef struct packed {
        logic        [4:0]  result_flow;
        logic signed [31:0] new_amplitude;
        logic        [1:0]  clamp_code;
    } result_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic absval;
        logic pp_lo;
        logic pp_hi;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

endpackage

// ----- sv/wpa_controller.sv -----
// Sequencer for the weighted projection amplitude block.
// Steps multiply, accumulate, magnitude product and bit-serial divide; uses wpa_pkg.
module wpa_controller
    import wpa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    localparam int DCW = $clog2(DIV_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_ABS,
        S_PP0,
        S_PP1,
        S_DIV,
        S_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = status.last ? S_ABS : S_IDLE;
            S_ABS:  state_next = S_PP0;
            S_PP0:  state_next = S_PP1;
            S_PP1:  state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == DCW'(DIV_BITS - 1))
                begin
                    state_next   = S_DONE;
                    div_cnt_next = '0;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && start;
        cmd.mul      = (state_reg == S_MUL);
        cmd.acc      = (state_reg == S_ACC);
        cmd.absval   = (state_reg == S_ABS);
        cmd.pp_lo    = (state_reg == S_PP0);
        cmd.pp_hi    = (state_reg == S_PP1);
        cmd.div_step = (state_reg == S_DIV);
        cmd.finish   = (state_reg == S_DONE);
    end

`ifndef NO_ASSERTIONS
    a_div_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DIV) |-> (div_cnt_reg == '0))
        else $error("divide counter running outside divide");
    a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_MUL))
        else $error("accepted sample did not enter multiply");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> (state_reg == S_IDLE))
        else $error("finish not followed by idle");
`endif

endmodule

// ----- sv/wpa_datapath.sv -----
// Datapath for the weighted projection amplitude block: products, saturating sums,
// split magnitude product, restoring divider and clamp. Uses wpa_pkg.
module wpa_datapath
    import wpa_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  sample_t     sample,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output status_t     status,
    output logic        done,
    output result_t     result
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    // control and state registers
    logic signed [31:0]    min_amp_reg, max_amp_reg;
    logic signed [SUM_W-1:0] num_reg, den_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  done_reg;

    // payload registers
    logic signed [23:0]       om_reg, mm_reg;
    logic        [23:0]       ww_reg;
    logic signed [31:0]       prior_reg;
    logic        [4:0]        flow_reg;
    logic                     last_reg;
    logic signed [TERM_W-1:0] tn_reg, td_reg;
    logic        [31:0]       pa_reg;
    logic        [SUM_W-1:0]  na_reg;
    logic                     neg_reg;
    logic        [PROD_W-1:0] prod_reg, q_reg;
    logic        [SUM_W-1:0]  rem_reg;
    result_t                  result_reg, result_next;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  s,
        input logic signed [TERM_W-1:0] t
    );
        logic [SUM_W:0] r;
        begin
            r = {s[SUM_W-1], s} + {{(SUM_W - TERM_W + 1){t[TERM_W-1]}}, t};
            if (r[SUM_W] != r[SUM_W-1])
                return r[SUM_W] ? SUM_MIN : SUM_MAX;
            return r[SUM_W-1:0];
        end
    endfunction

    logic signed [23:0]       om, mm;
    logic        [23:0]       ww;
    logic signed [48:0]       tn_full, td_full;
    logic        [31:0]       pa;
    logic        [SUM_W-1:0]  na;
    logic        [59:0]       pp_lo, pp_hi;
    logic        [SUM_W:0]    rem_shift, rem_diff;
    logic                     rem_ge;
    logic                     over;
    logic        [MAG_W-1:0]  mag;
    logic signed [MAG_W:0]    val, min_x, max_x;

    assign om = $signed(sample.observed_sample) * $signed(sample.model_sample);
    assign mm = $signed(sample.model_sample) * $signed(sample.model_sample);
    assign ww = sample.emphasis_weight * sample.emphasis_weight;

    assign tn_full = om_reg * $signed({1'b0, ww_reg});
    assign td_full = mm_reg * $signed({1'b0, ww_reg});

    assign pa = prior_reg[31] ? 32'(-prior_reg) : prior_reg;
    assign na = num_reg[SUM_W-1] ? SUM_W'(-num_reg) : num_reg;

    assign pp_lo = pa_reg * na_reg[27:0];
    assign pp_hi = pa_reg * na_reg[SUM_W-1:28];

    // one quotient bit a step
    assign rem_shift = {rem_reg, prod_reg[PROD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    assign over  = (|q_reg[PROD_W-1:MAG_W]) || (q_reg[MAG_W-1] && (|q_reg[MAG_W-2:0]));
    assign mag   = over ? QUOT_CAP : q_reg[MAG_W-1:0];
    assign min_x = {{(MAG_W - 31){min_amp_reg[31]}}, min_amp_reg};
    assign max_x = {{(MAG_W - 31){max_amp_reg[31]}}, max_amp_reg};

    always_comb
    begin
        val = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        result_next.result_flow = flow_reg;
        result_next.clamp_code  = CLAMP_NONE;
        // min first, then max: inverted limits end at max
        if (val < min_x)
        begin
            val = min_x;
            result_next.clamp_code = CLAMP_MIN;
        end
        if (val > max_x)
        begin
            val = max_x;
            result_next.clamp_code = CLAMP_MAX;
        end
        result_next.new_amplitude = val[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_amp_reg <= MIN_AMP_RESET;
            max_amp_reg <= MAX_AMP_RESET;
            num_reg     <= '0;
            den_reg     <= EPSILON_Q16;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_AMP: min_amp_reg <= cfg_data;
                    CFG_MAX_AMP: max_amp_reg <= cfg_data;
                    default: ;
                endcase
            end
            // drop samples past the flow limit
            if (cmd.acc && (cnt_reg < CW'(MAX_POINTS)))
            begin
                num_reg <= sat_add(num_reg, tn_reg);
                den_reg <= sat_add(den_reg, td_reg);
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.finish)
            begin
                num_reg <= '0;
                den_reg <= EPSILON_Q16;
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            om_reg    <= om;
            mm_reg    <= mm;
            ww_reg    <= ww;
            prior_reg <= sample.prior_amplitude;
            flow_reg  <= sample.flow_number;
            last_reg  <= sample.last_sample;
        end
        if (cmd.mul)
        begin
            tn_reg <= tn_full[TERM_W-1:0];
            td_reg <= td_full[TERM_W-1:0];
        end
        if (cmd.absval)
        begin
            pa_reg  <= pa;
            na_reg  <= na;
            neg_reg <= prior_reg[31] ^ num_reg[SUM_W-1];
            rem_reg <= '0;
            q_reg   <= '0;
        end
        if (cmd.pp_lo)
            prod_reg <= {28'b0, pp_lo};
        if (cmd.pp_hi)
            prod_reg <= prod_reg + {pp_hi, 28'b0};
        if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? rem_diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
            q_reg    <= {q_reg[PROD_W-2:0], rem_ge};
            prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
        end
        if (cmd.finish)
            result_reg <= result_next;
    end

    assign status.last = last_reg;
    assign done        = done_reg;
    assign result      = result_reg;

`ifndef NO_ASSERTIONS
    a_den_floor: assert property (@(posedge clk) disable iff (!rst_n)
        den_reg >= EPSILON_Q16)
        else $error("denominator below safety constant");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (rem_reg < den_reg))
        else $error("divider remainder not below denominator");
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (num_reg == '0 && cnt_reg == '0))
        else $error("sums not cleared after result");
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.clamp_code == CLAMP_NONE || result.clamp_code == CLAMP_MIN ||
                  result.clamp_code == CLAMP_MAX))
        else $error("bad clamp code");
`endif

endmodule

// ----- sv/weighted_projection_amplitude_top.sv -----
// Top level of the weighted projection amplitude block.
// Joins wpa_controller and wpa_datapath; uses wpa_pkg.
//
// Usage:
//   Drive one trace sample on sample and raise start; the transfer happens at
//   the rising edge where start is high and busy is low. Each sample adds
//   observed*model*w*w and model*model*w*w into two saturating 56-bit sums.
//   A sample without last_sample forms the 12x12 products, then the 24x25 multiply,
//   then the saturating add. A sample with last_sample continues to the result: the
//   magnitude product |prior|*|num| is built from two 32x28 partial products, then
//   a restoring divider gives one quotient bit a cycle for its 88-bit quotient.
//   done is high for one cycle with result, in the cycle where start may already
//   be taken again. The receiver cannot stall; every result transfer completes
//   in its cycle.
//   Configuration: cfg_we writes cfg_data to register cfg_index at once
//   (0 min_amplitude, 1 max_amplitude, others ignored); write only while idle.
//   Reset: limits return to their defaults, sums clear with the denominator at
//   its safety constant; there is no clearing pass.
module weighted_projection_amplitude_top
    import wpa_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  sample_t     sample,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output result_t     result
);

    cmd_t    cmd;
    status_t status;

    wpa_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    wpa_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .done      (done),
        .result    (result)
    );

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without work in progress");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");
`endif

endmodule

// ----- bench/weighted_projection_amplitude_top_tb.sv -----
// Self-checking testbench for weighted_projection_amplitude_top.
// Drives sample transfers, predicts each projected amplitude and checks it against the result port.
// Depends on wpa_pkg and the weighted_projection_amplitude_top RTL.
module weighted_projection_amplitude_top_tb;
    import wpa_pkg::*;

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     PHASE_ITEMS = 200;
    localparam int     FLOW_CAP    = 64;
    localparam int     DRAIN_WAIT  = 120;
    localparam longint ACC_MAX     = (64'sd1 <<< 55) - 1;
    localparam longint ACC_MIN     = -(64'sd1 <<< 55);
    localparam longint ACC_START   = 7;
    localparam logic [127:0] QUOT_LIMIT = 128'd1 << 40;
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    typedef struct {
        sample_t s;
        bit      typed;
        result_t want;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    sample_t     sample;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    result_t     result;

    weighted_projection_amplitude_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    // Predictor state
    longint             num_acc;
    longint             den_acc;
    int                 points_taken;
    logic signed [31:0] amp_floor;
    logic signed [31:0] amp_ceiling;

    result_t       amplitude_expected[$];
    directed_row_t directed_rows[$];
    int            error_count;
    int            cycle_count;
    bit            no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic longint acc_clip(longint x);
        if (x > ACC_MAX)
            return ACC_MAX;
        if (x < ACC_MIN)
            return ACC_MIN;
        return x;
    endfunction

    function automatic void clear_accumulators();
        num_acc      = 0;
        den_acc      = ACC_START;
        points_taken = 0;
    endfunction

    // Advance the predictor by one sample; returns 1 when the sample closes a flow.
    function automatic bit project_sample(input sample_t s, output result_t r);
        longint       o;
        longint       m;
        longint       w2;
        longint       prior;
        longint       v;
        logic [63:0]  pa;
        logic [63:0]  na;
        logic [127:0] prod;
        logic [127:0] quot;
        bit           neg;
        r  = '0;
        o  = longint'($signed(s.observed_sample));
        m  = longint'($signed(s.model_sample));
        w2 = longint'(s.emphasis_weight);
        w2 = w2 * w2;
        if (points_taken < FLOW_CAP)
        begin
            num_acc = acc_clip(num_acc + o * m * w2);
            den_acc = acc_clip(den_acc + m * m * w2);
            points_taken++;
        end
        if (!s.last_sample)
            return 1'b0;
        prior = longint'($signed(s.prior_amplitude));
        neg   = (prior < 0) != (num_acc < 0);
        pa    = (prior < 0) ? -prior : prior;
        na    = (num_acc < 0) ? -num_acc : num_acc;
        prod  = {64'd0, pa} * {64'd0, na};
        quot  = prod / {64'd0, den_acc};
        if (quot > QUOT_LIMIT)
            quot = QUOT_LIMIT;
        v = neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
        r.clamp_code = CLAMP_NONE;
        // min clamp first, so inverted limits end at the ceiling
        if (v < longint'(amp_floor))
        begin
            v            = longint'(amp_floor);
            r.clamp_code = CLAMP_MIN;
        end
        if (v > longint'(amp_ceiling))
        begin
            v            = longint'(amp_ceiling);
            r.clamp_code = CLAMP_MAX;
        end
        r.result_flow   = s.flow_number;
        r.new_amplitude = v[31:0];
        clear_accumulators();
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
            flag_error($sformatf("%s expected %0d got %0d", field, want, got));
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (amplitude_expected.size() == 0)
                flag_error($sformatf("unexpected result flow %0d amplitude %0d",
                                     result.result_flow, $signed(result.new_amplitude)));
            else
            begin
                want = amplitude_expected.pop_front();
                check_field("result_flow", longint'(want.result_flow),
                            longint'(result.result_flow));
                check_field("new_amplitude", longint'($signed(want.new_amplitude)),
                            longint'($signed(result.new_amplitude)));
                check_field("clamp_code", longint'(want.clamp_code),
                            longint'(result.clamp_code));
            end
        end
    end

    // One sample transfer; gaps are drawn per item.
    task automatic send_sample(input sample_t s, input bit typed, input result_t typed_res);
        int      gap;
        result_t r;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample <= s;
        start  <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        if (project_sample(s, r))
            amplitude_expected.push_back(typed ? typed_res : r);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_MIN_AMP)
            amp_floor = data;
        else if (idx == CFG_MAX_AMP)
            amp_ceiling = data;
    endtask

    // Drain the block, then load new clamp limits plus one write to an unused index.
    task automatic set_limits(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [1:0] spare);
        @(negedge clk);
        start <= 1'b0;
        while (amplitude_expected.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        while (busy)
            @(negedge clk);
        cfg_write(CFG_MIN_AMP, lo);
        cfg_write(CFG_MAX_AMP, hi);
        cfg_write(spare, $urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_row(input int obs, input int mdl, input int w,
                                    input longint prior, input int flow, input bit last,
                                    input bit typed = 1'b0, input longint amp = 0,
                                    input logic [1:0] code = CLAMP_NONE);
        directed_row_t row;
        row.s.observed_sample      = obs[11:0];
        row.s.model_sample         = mdl[11:0];
        row.s.emphasis_weight      = w[11:0];
        row.s.prior_amplitude      = prior[31:0];
        row.s.flow_number          = flow[4:0];
        row.s.last_sample          = last;
        row.typed                  = typed;
        row.want.result_flow       = flow[4:0];
        row.want.new_amplitude     = amp[31:0];
        row.want.clamp_code        = code;
        directed_rows.push_back(row);
    endfunction

    initial
    begin
        sample_t s;
        int      phase;
        int      sent;
        int      len;
        int      flow;
        int      gain;
        int      prior_v;
        int      mdl;
        int      obs;
        int      pick;
        bit      coherent;
        logic [31:0] lo;
        logic [31:0] hi;

        rst_n       = 1'b0;
        start       = 1'b0;
        sample      = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_MIN_AMP;
        cfg_data    = '0;
        error_count = 0;
        cycle_count = 0;
        no_gaps     = 1'b0;
        amp_floor   = MIN_AMP_RESET;
        amp_ceiling = MAX_AMP_RESET;
        clear_accumulators();

        // Single-sample flows with typed results, most of them plain from the limits
        add_row(0, 0, 0, 65536, 0, 1'b1, 1'b1, MIN_AMP_RESET, CLAMP_MIN);
        add_row(2047, 2047, 4095, 65536, 31, 1'b1, 1'b1, 65535, CLAMP_NONE);
        add_row(-2048, 2047, 4095, 2147483647, 1, 1'b1, 1'b1, MIN_AMP_RESET, CLAMP_MIN);
        add_row(2047, 1, 4095, 2147483647, 2, 1'b1, 1'b1, MAX_AMP_RESET, CLAMP_MAX);
        add_row(-2048, 2047, 4095, -2147483648, 3, 1'b1, 1'b1, MAX_AMP_RESET, CLAMP_MAX);
        add_row(-2048, -2048, 4095, -2147483648, 4, 1'b1, 1'b1, MIN_AMP_RESET, CLAMP_MIN);
        add_row(2047, -2048, 0, -2147483648, 21, 1'b1, 1'b1, MIN_AMP_RESET, CLAMP_MIN);
        // Multi-sample and single-sample flows, predicted
        add_row(100, 50, 256, 0, 5, 1'b0);
        add_row(-300, 200, 512, 0, 5, 1'b0);
        add_row(2047, -2048, 4095, 0, 5, 1'b0);
        add_row(10, 10, 128, 3 * 65536, 5, 1'b1);
        add_row(-1365, 1365, 2730, 0, 6, 1'b0);
        add_row(682, -682, 1365, 0, 6, 1'b0);
        add_row(-5, 7, 4095, -65536, 6, 1'b1);
        add_row(1000, 1000, 256, 655360, 10, 1'b1);
        add_row(400, 200, 1, 0, 7, 1'b0);
        add_row(-800, -400, 4000, 0, 7, 1'b0);
        add_row(1, -1, 4095, 0, 7, 1'b0);
        add_row(600, 300, 256, 2147483647, 7, 1'b1);
        add_row(-2048, -1, 4095, 1, 16, 1'b1);
        add_row(3, 2047, 3000, 65536 * 4, 8, 1'b1);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
                1: begin lo = 32'd327680;    hi = 32'd131072;    end
                2: begin lo = 32'd65536;     hi = 32'd65536;     end
                3:
                begin
                    lo = -$urandom_range(0, 1310720);
                    hi = $urandom_range(0, 1310720);
                end
                default: begin lo = MIN_AMP_RESET; hi = MAX_AMP_RESET; end
            endcase
            set_limits(lo, hi, phase[0] ? CFG_SPARE_3 : CFG_SPARE_2);

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // mostly short flows, now and then one near or past the point cap
                len      = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80)
                                                       : $urandom_range(1, 16);
                flow     = $urandom_range(0, 31);
                gain     = $urandom_range(0, 48) - 24;
                coherent = $urandom_range(0, 1);
                no_gaps  = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0)
                    prior_v = $urandom;
                else
                    prior_v = $urandom_range(0, 2097152) - 1048576;
                for (int k = 0; k < len; k++)
                begin
                    pick = $urandom_range(0, 15);
                    mdl  = $urandom_range(0, 4095) - 2048;
                    if (pick == 0)
                        mdl = 2047;
                    else if (pick == 1)
                        mdl = -2048;
                    if (coherent)
                    begin
                        obs = mdl * gain / 4 + int'($urandom_range(0, 64)) - 32;
                        if (obs > 2047)
                            obs = 2047;
                        if (obs < -2048)
                            obs = -2048;
                    end
                    else
                        obs = $urandom_range(0, 4095) - 2048;
                    s.observed_sample = obs[11:0];
                    s.model_sample    = mdl[11:0];
                    s.emphasis_weight = ($urandom_range(0, 7) == 0)
                                        ? 12'($urandom_range(0, 15))
                                        : 12'($urandom_range(0, 4095));
                    // the prior only matters on the closing sample; scramble it elsewhere
                    s.last_sample     = (k == len - 1);
                    s.prior_amplitude = s.last_sample ? prior_v : $urandom;
                    s.flow_number     = (!s.last_sample && $urandom_range(0, 3) == 0)
                                        ? 5'($urandom_range(0, 31)) : flow[4:0];
                    send_sample(s, 1'b0, '0);
                    sent++;
                end
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (amplitude_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/wpa_pkg.sv
sv/wpa_controller.sv
sv/wpa_datapath.sv
sv/weighted_projection_amplitude_top.sv
bench/weighted_projection_amplitude_top_tb.sv
